[hdl/arp_pkg.sv]
package arp_pkg;

	// Field widths
	localparam int IP_W  = 32;
	localparam int MAC_W = 48;

	// Default table depth
	localparam int ENTRIES_DEF = 16;

	// Operation codes; code 3 is unused and answers as a miss
	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_HIT     = 3'd0,
		ST_MISS    = 3'd1,
		ST_NEW     = 3'd2,
		ST_UPDATED = 3'd3,
		ST_FULL    = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	// Request presented to the table
	typedef struct packed {
		logic             en;
		op_t              op;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} cam_req_t;

	// Answer from the table for the current request
	typedef struct packed {
		logic             hit;
		logic [MAC_W-1:0] mac;
		status_t          status;
	} cam_rsp_t;

endpackage

[hdl/arp_cam.sv]
module arp_cam #(
	parameter int ENTRIES = arp_pkg::ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  arp_pkg::cam_req_t req,
	output arp_pkg::cam_rsp_t rsp,
	output logic [ENTRIES-1:0] match
);

	logic [ENTRIES-1:0]            valid_q;
	logic [arp_pkg::IP_W-1:0]      ip_q  [ENTRIES];
	logic [arp_pkg::MAC_W-1:0]     mac_q [ENTRIES];

	logic [ENTRIES-1:0]            free_oh;
	logic                          match_any;
	logic                          full;
	logic [arp_pkg::MAC_W-1:0]     mac_sel;

	// Parallel key compare against every valid slot
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (ip_q[i] == req.ip);
		end
	end

	// At most one slot matches, so an OR of the gated entries selects it
	always_comb begin
		mac_sel = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				mac_sel = mac_sel | mac_q[i];
			end
		end
	end

	// Lowest free slot as a one-hot vector; zero when the table is full
	assign free_oh   = ~valid_q & (valid_q + ENTRIES'(1));
	assign full      = &valid_q;
	assign match_any = |match;

	// Result for the current request
	always_comb begin
		rsp.hit    = 1'b0;
		rsp.mac    = '0;
		rsp.status = arp_pkg::ST_MISS;
		unique case (req.op)
			arp_pkg::OP_LOOKUP: begin
				rsp.hit = match_any;
				if (match_any) begin
					rsp.mac    = mac_sel;
					rsp.status = arp_pkg::ST_HIT;
				end
			end
			arp_pkg::OP_INSERT: begin
				rsp.hit = match_any;
				if (match_any) begin
					rsp.status = arp_pkg::ST_UPDATED;
				end else if (full) begin
					rsp.status = arp_pkg::ST_FULL;
				end else begin
					rsp.status = arp_pkg::ST_NEW;
				end
			end
			arp_pkg::OP_CLEAR: begin
				rsp.status = arp_pkg::ST_CLEARED;
			end
			default: begin
				rsp.status = arp_pkg::ST_MISS;
			end
		endcase
	end

	// Valid bits: set on a new insert, all dropped on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.en) begin
			if (req.op == arp_pkg::OP_CLEAR) begin
				valid_q <= '0;
			end else if (req.op == arp_pkg::OP_INSERT && !match_any) begin
				valid_q <= valid_q | free_oh;
			end
		end
	end

	// Key and MAC storage, no reset
	always_ff @(posedge clk) begin
		if (req.en && req.op == arp_pkg::OP_INSERT) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (match[i]) begin
					mac_q[i] <= req.mac;
				end else if (!match_any && free_oh[i]) begin
					ip_q[i]  <= req.ip;
					mac_q[i] <= req.mac;
				end
			end
		end
	end

endmodule

[hdl/arp_ip_to_mac_table.sv]
// ARP cache holding up to ENTRIES IPv4-to-MAC mappings, all compared in
// parallel on the full 32-bit address. Each request is a lookup, an insert
// (updates a present key or fills the lowest free slot, dropped with status
// full when no slot is free) or a clear of the whole table; each gives
// exactly one response. One request is accepted every clock cycle while the
// response register is free or drained by rsp_ready; the request is
// registered, then the compare across all slots and the table write happen
// together as it moves into the response register, so a request always sees
// the table left by the one before it. Valid bits are cleared by reset, so
// the table is usable immediately with no clearing pass.
module arp_ip_to_mac_table #(
	parameter int ENTRIES = arp_pkg::ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [1:0]                operation,
	input  logic [arp_pkg::IP_W-1:0]  ip_addr,
	input  logic [arp_pkg::MAC_W-1:0] mac_addr,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic                      hit,
	output logic [arp_pkg::MAC_W-1:0] mac_out,
	output logic [2:0]                status
);

	logic                      valid_s1;
	arp_pkg::op_t              op_s1;
	logic [arp_pkg::IP_W-1:0]  ip_s1;
	logic [arp_pkg::MAC_W-1:0] mac_s1;

	logic                      rsp_valid_q;
	logic                      hit_q;
	logic [arp_pkg::MAC_W-1:0] mac_q;
	arp_pkg::status_t          status_q;

	logic                      advance;
	arp_pkg::cam_req_t         cam_req;
	arp_pkg::cam_rsp_t         cam_rsp;
	logic [ENTRIES-1:0]        cam_match;

	// Stage 1 moves into the response register when that is free or drained
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_s1  <= arp_pkg::op_t'(operation);
			ip_s1  <= ip_addr;
			mac_s1 <= mac_addr;
		end
	end

	// Table
	always_comb begin
		cam_req.en  = advance;
		cam_req.op  = op_s1;
		cam_req.ip  = ip_s1;
		cam_req.mac = mac_s1;
	end

	arp_cam #(
		.ENTRIES(ENTRIES)
	) u_cam (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (cam_req),
		.rsp   (cam_rsp),
		.match (cam_match)
	);

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q    <= cam_rsp.hit;
			mac_q    <= cam_rsp.mac;
			status_q <= cam_rsp.status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign hit       = hit_q;
	assign mac_out   = mac_q;
	assign status    = status_q;

	// Assertions
	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(cam_match))
		else $error("several slots hold the same key");

	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && hit) |-> (status == arp_pkg::ST_HIT || status == arp_pkg::ST_UPDATED))
		else $error("hit flag with a non-hit status");

	a_mac_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && mac_out != '0) |-> (hit && status == arp_pkg::ST_HIT))
		else $error("MAC returned without a lookup hit");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == arp_pkg::OP_CLEAR) |=> (cam_match == '0))
		else $error("slot still matches after clear");

endmodule
